// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply package
// Codes, widths and shared types of the fixed-point matrix product block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 36;
  localparam int RES_W  = 32;
  localparam int IDX_W  = 4;
  localparam int DIM_W  = 5;
  localparam int ACT_W  = 2;
  localparam int REG_W  = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// File: design/mm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply MAC unit
// Registered signed multiplier, wide accumulator and saturation to Q16.16.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [mm_pkg::VAL_W-1:0]   a_i,
  input  logic signed [mm_pkg::VAL_W-1:0]   b_i,
  output logic                              busy,
  output logic signed [mm_pkg::RES_W-1:0]   result
);

  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic                             prod_vld_r;
  logic signed [mm_pkg::ACC_W-1:0]  acc_r;
  logic [mm_pkg::ACC_W-mm_pkg::RES_W:0] top_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod_r <= a_i * b_i;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + mm_pkg::ACC_W'(prod_r);
    end
  end

  assign top_bits = acc_r[mm_pkg::ACC_W-1:mm_pkg::RES_W-1];
  assign busy     = prod_vld_r;

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result = acc_r[mm_pkg::RES_W-1:0];
    end else if (acc_r[mm_pkg::ACC_W-1]) begin
      result = {1'b1, {(mm_pkg::RES_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(mm_pkg::RES_W-1){1'b1}}};
    end
  end

endmodule

// File: design/matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply
// Fixed-point dense matrix product C = A x B delivered one result row at a time.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ stream. A load transfer writes one Q8.8 element
// of A or B; out-of-range loads are dropped. A compute transfer names a result
// row; the block then produces cols_b Q16.16 elements on the out_ stream in
// column order, with out_tlast on the last one. Each element is a dot product
// over inner_dim terms on one shared multiplier and accumulator: inner_dim
// memory reads, then pipeline drain and output load. in_tready is low while a
// row is being computed.
// The output register frees the input side: a new item is taken while the
// final element still waits. When the receiver stalls, the block holds the
// next finished element until the output register empties.
// Reset returns the sequencer to idle, empties the output register and sets
// the three dimension registers to 16. Matrix stores are not cleared; an
// element must be loaded before it is used.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // row_index[3:0], col_index[7:4], value[23:8]
  input  logic [23:0]                in_tdata,
  // action[1:0]
  input  logic [mm_pkg::ACT_W-1:0]   in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // element[31:0], out_row[35:32], out_col[39:36]
  output logic [39:0]                out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [mm_pkg::REG_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]   cfg_wdata
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LIM_INT = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam logic [mm_pkg::DIM_W-1:0] LIM = mm_pkg::DIM_W'(LIM_INT);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [mm_pkg::IDX_W-1:0] r,
                                                input logic [mm_pkg::IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic [mm_pkg::DIM_W-1:0] clamp_dim(input logic [mm_pkg::DIM_W-1:0] v);
    logic [mm_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = mm_pkg::DIM_W'(1);
    end else if (v > LIM) begin
      res = LIM;
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [mm_pkg::IDX_W-1:0] in_row;
  logic [mm_pkg::IDX_W-1:0] in_col;
  logic [mm_pkg::VAL_W-1:0] in_value;
  logic                     in_fire;

  logic [mm_pkg::DIM_W-1:0] rows_a_r;
  logic [mm_pkg::DIM_W-1:0] inner_dim_r;
  logic [mm_pkg::DIM_W-1:0] cols_b_r;
  logic [mm_pkg::DIM_W-1:0] nr;

  mm_pkg::state_t state_r;
  mm_pkg::state_t state_nxt;

  logic [mm_pkg::IDX_W-1:0] row_r;
  logic [mm_pkg::IDX_W-1:0] k_r;
  logic [mm_pkg::IDX_W-1:0] j_r;
  logic [mm_pkg::DIM_W-1:0] nk_r;
  logic [mm_pkg::DIM_W-1:0] nc_r;

  logic start;
  logic issue;
  logic out_load;
  logic next_col;
  logic out_free;
  logic k_last;
  logic col_last;
  logic in_range;

  logic [mm_pkg::VAL_W-1:0] a_mem [DEPTH];
  logic [mm_pkg::VAL_W-1:0] b_mem [DEPTH];
  logic [mm_pkg::VAL_W-1:0] a_rd_r;
  logic [mm_pkg::VAL_W-1:0] b_rd_r;
  logic                     rd_vld_r;
  logic                     a_we;
  logic                     b_we;
  logic [ADDR_W-1:0]        waddr;

  mm_pkg::mac_ctrl_t               mac_ctrl;
  logic                            mac_busy;
  logic signed [mm_pkg::RES_W-1:0] mac_result;

  logic                            out_tvalid_r;
  logic [mm_pkg::RES_W-1:0]        out_elem_r;
  logic [mm_pkg::IDX_W-1:0]        out_row_r;
  logic [mm_pkg::IDX_W-1:0]        out_col_r;
  logic                            out_last_r;

  assign in_row   = in_tdata[3:0];
  assign in_col   = in_tdata[7:4];
  assign in_value = in_tdata[23:8];
  assign in_fire  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      cols_b_r    <= mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mm_pkg::REG_ROWS_A:    rows_a_r    <= cfg_wdata;
        mm_pkg::REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        mm_pkg::REG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nr       = clamp_dim(rows_a_r);
  assign in_range = ({1'b0, in_row} < nr);
  assign out_free = !out_tvalid_r || out_tready;
  assign k_last   = ({1'b0, k_r} == nk_r - 1'b1);
  assign col_last = ({1'b0, j_r} == nc_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm_pkg::ST_IDLE: begin
        if (in_fire && in_tuser == mm_pkg::ACT_COMPUTE && in_range) begin
          state_nxt = mm_pkg::ST_MAC;
        end
      end
      mm_pkg::ST_MAC: begin
        if (k_last) begin
          state_nxt = mm_pkg::ST_DRAIN;
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = mm_pkg::ST_EMIT;
        end
      end
      mm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = col_last ? mm_pkg::ST_IDLE : mm_pkg::ST_MAC;
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    next_col  = 1'b0;
    case (state_r)
      mm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        start     = in_fire && in_tuser == mm_pkg::ACT_COMPUTE && in_range;
      end
      mm_pkg::ST_MAC: begin
        issue = 1'b1;
      end
      mm_pkg::ST_DRAIN: ;
      mm_pkg::ST_EMIT: begin
        out_load = out_free;
        next_col = out_free && !col_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_r <= in_row;
      nk_r  <= clamp_dim(inner_dim_r);
      nc_r  <= clamp_dim(cols_b_r);
      j_r   <= '0;
      k_r   <= '0;
    end else if (next_col) begin
      j_r <= j_r + 1'b1;
      k_r <= '0;
    end else if (issue) begin
      k_r <= k_r + 1'b1;
    end
  end

  assign waddr = addr_of(in_row, in_col);
  assign a_we  = in_fire && in_tuser == mm_pkg::ACT_LOAD_A &&
                 ({1'b0, in_row} < LIM) && ({1'b0, in_col} < LIM);
  assign b_we  = in_fire && in_tuser == mm_pkg::ACT_LOAD_B &&
                 ({1'b0, in_row} < LIM) && ({1'b0, in_col} < LIM);

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[waddr] <= in_value;
    end
    a_rd_r <= a_mem[addr_of(row_r, k_r)];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[waddr] <= in_value;
    end
    b_rd_r <= b_mem[addr_of(k_r, j_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
  end

  assign mac_ctrl.clear = start || next_col;
  assign mac_ctrl.valid = rd_vld_r;

  mm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .a_i    (a_rd_r),
    .b_i    (b_rd_r),
    .busy   (mac_busy),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_elem_r <= mac_result;
      out_row_r  <= row_r;
      out_col_r  <= j_r;
      out_last_r <= col_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_col_r, out_row_r, out_elem_r};
  assign out_tlast  = out_last_r;

endmodule

// File: design/mm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply checker
// Port-level assertions on the matrix multiply block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [mm_pkg::ACT_W-1:0] in_tuser,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [39:0]              out_tdata,
  input logic                     out_tlast
);

  `ASSERT_CHK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "Result changed while stalled")
  `ASSERT_CHK(a_load_ready, in_tvalid && in_tready && (in_tuser != mm_pkg::ACT_COMPUTE) |=> in_tready, "Block left idle after a non-compute transfer")
  `ASSERT_CHK(a_row_busy, out_tvalid && !out_tlast |-> !in_tready, "Input accepted in the middle of a result row")
  `ASSERT_ALL(a_reset_idle, !rst_n |=> !out_tvalid && in_tready, "Block not idle after reset")

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
